FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// clocked checks on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge out of reset
`define ATC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition implies property in the next cycle
`define ATC_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

FILE: rtl/atc_pkg.sv
// ----------------------------------------------------------------------------
// atc_pkg
// shared widths, constants and types of the adc code to temperature unit
// ----------------------------------------------------------------------------
package atc_pkg;

	localparam int CODE_W    = 12;
	localparam int CFG_IDX_W = 2;
	localparam int NUM_W     = CODE_W + 8;
	localparam int QUO_W     = NUM_W - 1;
	localparam int REM_W     = CODE_W + 1;
	localparam int CNT_W     = $clog2(QUO_W);
	localparam int SLOPE_W   = 14;
	localparam int ACC_W     = 32;
	localparam int MAG_W     = 27;
	localparam int RECIP_W   = 32;
	localparam int RECIP_SH  = 35;
	localparam int P1_W      = MAG_W + RECIP_W;
	localparam int Q1_W      = P1_W - RECIP_SH;
	localparam int P2_W      = Q1_W + RECIP_W;
	localparam int Q2_W      = P2_W - RECIP_SH;
	localparam int TEMP_W    = 16;
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = $clog2(QDEPTH);

	localparam logic [CFG_IDX_W-1:0] CFG_CAL_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CAL_HIGH = 2'd1;

	localparam int T_LOW_K   = 85;
	localparam int T_HIGH_K  = 30;
	localparam int SLOPE_NUM = -5500;
	localparam logic signed [7:0] ICPT_SCALE = 8'sd100;
	localparam logic [RECIP_W-1:0] RECIP_10 = 32'hCCCC_CCCD;

	typedef struct packed {
		logic                      busy;
		logic                      err;
		logic signed [ACC_W-1:0]   icpt;
		logic signed [SLOPE_W-1:0] slope;
	} coef_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              err;
	} item_t;

endpackage

FILE: rtl/atc_coef.sv
// ----------------------------------------------------------------------------
// atc_coef
// calibration registers and a shared serial divider for slope and intercept
// ----------------------------------------------------------------------------
module atc_coef (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [atc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [atc_pkg::CODE_W-1:0]       cfg_data,
	output atc_pkg::coef_t                   coef
);

	typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_DIV, ST_FIN} state_t;

	state_t                            state_q;
	logic                              pass_q;
	logic [atc_pkg::CNT_W-1:0]         cnt_q;
	logic [atc_pkg::CODE_W-1:0]        low_q, high_q;
	logic [atc_pkg::CODE_W-1:0]        dmag_q;
	logic [atc_pkg::QUO_W-1:0]         quo_q;
	logic [atc_pkg::REM_W-1:0]         rem_q;
	logic                              qneg_q;
	logic                              err_q;
	logic signed [atc_pkg::ACC_W-1:0]   icpt_q;
	logic signed [atc_pkg::SLOPE_W-1:0] slope_q;

	logic signed [atc_pkg::NUM_W-1:0]   num;
	logic signed [atc_pkg::REM_W-1:0]   dif;
	logic [atc_pkg::REM_W-1:0]          rem_n;
	logic                               ge;
	logic signed [atc_pkg::NUM_W-1:0]   qs;

	always_comb begin
		dif = atc_pkg::REM_W'(int'(low_q) - int'(high_q));
		if (pass_q) begin
			num = atc_pkg::NUM_W'(atc_pkg::SLOPE_NUM);
		end else begin
			num = atc_pkg::NUM_W'(atc_pkg::T_LOW_K * int'(low_q)
				- atc_pkg::T_HIGH_K * int'(high_q));
		end
		rem_n = {rem_q[atc_pkg::REM_W-2:0], quo_q[atc_pkg::QUO_W-1]};
		ge    = rem_n >= {1'b0, dmag_q};
		qs    = qneg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pass_q  <= 1'b0;
			cnt_q   <= '0;
			low_q   <= '0;
			high_q  <= '0;
			err_q   <= 1'b1;
			dmag_q  <= '0;
			quo_q   <= '0;
			rem_q   <= '0;
			qneg_q  <= 1'b0;
			icpt_q  <= '0;
			slope_q <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == atc_pkg::CFG_CAL_LOW) begin
				low_q <= cfg_data;
			end
			if (cfg_index == atc_pkg::CFG_CAL_HIGH) begin
				high_q <= cfg_data;
			end
			state_q <= ST_LOAD;
			pass_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
				end
				ST_LOAD: begin
					err_q  <= dif == '0;
					dmag_q <= atc_pkg::CODE_W'(dif[atc_pkg::REM_W-1] ? -dif : dif);
					quo_q  <= atc_pkg::QUO_W'(num[atc_pkg::NUM_W-1] ? -num : num);
					qneg_q <= num[atc_pkg::NUM_W-1] ^ dif[atc_pkg::REM_W-1];
					rem_q  <= '0;
					cnt_q  <= '0;
					state_q <= (dif == '0) ? ST_IDLE : ST_DIV;
				end
				ST_DIV: begin
					rem_q <= ge ? rem_n - {1'b0, dmag_q} : rem_n;
					quo_q <= {quo_q[atc_pkg::QUO_W-2:0], ge};
					cnt_q <= cnt_q + atc_pkg::CNT_W'(1);
					if (cnt_q == atc_pkg::CNT_W'(atc_pkg::QUO_W - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (pass_q) begin
						slope_q <= atc_pkg::SLOPE_W'(qs);
						state_q <= ST_IDLE;
					end else begin
						icpt_q  <= atc_pkg::ACC_W'(qs) * atc_pkg::ACC_W'(atc_pkg::ICPT_SCALE);
						pass_q  <= 1'b1;
						state_q <= ST_LOAD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign cfg_ready  = 1'b1;
	assign coef.busy  = state_q != ST_IDLE;
	assign coef.err   = err_q;
	assign coef.icpt  = icpt_q;
	assign coef.slope = slope_q;

endmodule

FILE: rtl/atc_front.sv
// ----------------------------------------------------------------------------
// atc_front
// accepts adc codes, tags them with the calibration status and queues them
// ----------------------------------------------------------------------------
module atc_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [atc_pkg::CODE_W-1:0] adc_code,
	input  atc_pkg::coef_t             coef,
	output logic                       head_valid,
	output atc_pkg::item_t             head,
	input  logic                       pop
);

	atc_pkg::item_t              entry_q [atc_pkg::QDEPTH];
	logic [atc_pkg::QPTR_W-1:0]  wr_q, rd_q;
	logic [atc_pkg::QPTR_W:0]    cnt_q;
	logic                        push, do_pop;

	assign in_ready   = (cnt_q != (atc_pkg::QPTR_W+1)'(atc_pkg::QDEPTH)) && !coef.busy;
	assign push       = in_valid && in_ready;
	assign head_valid = cnt_q != '0;
	assign do_pop     = pop && head_valid;
	assign head       = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= '{code: adc_code, err: coef.err};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + atc_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + atc_pkg::QPTR_W'(1);
			end
			cnt_q <= cnt_q + (atc_pkg::QPTR_W+1)'(push) - (atc_pkg::QPTR_W+1)'(do_pop);
		end
	end

endmodule

FILE: rtl/atc_back.sv
// ----------------------------------------------------------------------------
// atc_back
// six stage pipeline evaluating the calibration line, rounding and saturating
// ----------------------------------------------------------------------------
module atc_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              head_valid,
	input  atc_pkg::item_t                    head,
	output logic                              pop,
	input  atc_pkg::coef_t                    coef,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [atc_pkg::TEMP_W-1:0] temperature_c,
	output logic                              cal_error
);

	logic                               en;
	logic                               v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic                               e_s1, e_s2, e_s3, e_s4, e_s5;
	logic signed [atc_pkg::ACC_W-1:0]   prod_s1;
	logic                               neg_s2, neg_s3, neg_s4, neg_s5;
	logic [atc_pkg::MAG_W-1:0]          mag_s2;
	logic [atc_pkg::P1_W-1:0]           p_s3;
	logic [atc_pkg::Q1_W-1:0]           q1_s4, q1_s5;
	logic [atc_pkg::P2_W-1:0]           p_s5;
	logic signed [atc_pkg::TEMP_W-1:0]  temp_s6;
	logic                               err_s6;

	logic signed [atc_pkg::ACC_W-1:0]   t;
	logic [atc_pkg::Q2_W-1:0]           q2;
	logic [3:0]                         r;
	logic [atc_pkg::Q2_W:0]             up;
	logic signed [atc_pkg::TEMP_W-1:0]  deg;

	assign en  = !v_s6 || out_ready;
	assign pop = en;

	always_comb begin
		t  = prod_s1 + coef.icpt;
		q2 = p_s5[atc_pkg::P2_W-1:atc_pkg::RECIP_SH];
		r  = q1_s5[3:0] - 4'(q2 * 4'd10);
		up = {1'b0, q2} + (atc_pkg::Q2_W+1)'(r > 4'd4);
		if (neg_s5) begin
			deg = (q2 > atc_pkg::Q2_W'(32768)) ? 16'sh8000 : -$signed(atc_pkg::TEMP_W'(q2));
		end else begin
			deg = (up > (atc_pkg::Q2_W+1)'(32767)) ? 16'sh7FFF : $signed(atc_pkg::TEMP_W'(up));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6} <= '0;
		end else if (en) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6} <= {head_valid, v_s1, v_s2, v_s3, v_s4, v_s5};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= atc_pkg::ACC_W'(coef.slope)
				* atc_pkg::ACC_W'($signed({1'b0, head.code}));
			e_s1    <= head.err;
			neg_s2  <= t[atc_pkg::ACC_W-1];
			mag_s2  <= atc_pkg::MAG_W'(t[atc_pkg::ACC_W-1] ? -t : t);
			e_s2    <= e_s1;
			p_s3    <= atc_pkg::P1_W'(mag_s2) * atc_pkg::P1_W'(atc_pkg::RECIP_10);
			neg_s3  <= neg_s2;
			e_s3    <= e_s2;
			q1_s4   <= p_s3[atc_pkg::P1_W-1:atc_pkg::RECIP_SH];
			neg_s4  <= neg_s3;
			e_s4    <= e_s3;
			p_s5    <= atc_pkg::P2_W'(q1_s4) * atc_pkg::P2_W'(atc_pkg::RECIP_10);
			q1_s5   <= q1_s4;
			neg_s5  <= neg_s4;
			e_s5    <= e_s4;
			temp_s6 <= e_s5 ? '0 : deg;
			err_s6  <= e_s5;
		end
	end

	assign out_valid     = v_s6;
	assign temperature_c = temp_s6;
	assign cal_error     = err_s6;

endmodule

FILE: rtl/adc_code_to_temperature_unit.sv
// an accepted word is queued in the front end, then registered through the back end pipeline to the output register
// throughput: one word per cycle while out_ready is high and no recompute is running, set by the pipelined back end
// each calibration write holds off input while the serial divider
// recomputes slope and intercept (two passes of 19 iterations plus setup),
// or only for the setup step when the two codes are equal
// reset clears calibration codes to 0, so results flag cal_error until written
// ----------------------------------------------------------------------------
// adc_code_to_temperature_unit
// two point calibrated conversion of sensor adc codes to degrees celsius
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module adc_code_to_temperature_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [atc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [atc_pkg::CODE_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [atc_pkg::CODE_W-1:0]        adc_code,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [atc_pkg::TEMP_W-1:0] temperature_c,
	output logic                              cal_error
);

	atc_pkg::coef_t coef;
	atc_pkg::item_t head;
	logic           head_valid, pop;

	atc_coef u_coef (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coef      (coef)
	);

	atc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.adc_code   (adc_code),
		.coef       (coef),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	atc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (pop),
		.coef          (coef),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.temperature_c (temperature_c),
		.cal_error     (cal_error)
	);

	`ATC_ASSERT(a_no_accept_busy, in_ready |-> !coef.busy, "input taken during recompute")
	`ATC_ASSERT(a_err_zero, (out_valid && cal_error) |-> (temperature_c == '0), "error word nonzero")
	`ATC_ASSERT_NEXT(a_cfg_stall, cfg_valid && cfg_ready, !in_ready, "no stall after config write")

endmodule

FILE: bench/adc_code_to_temperature_unit_tb.sv
// ----------------------------------------------------------------------------
// adc_code_to_temperature_unit_tb
// drives adc codes under several calibration settings, predicts each
// temperature from the two point line fit and checks every output word
// ----------------------------------------------------------------------------
module adc_code_to_temperature_unit_tb;
	import atc_pkg::*;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [CODE_W-1:0]         cfg_data;
	logic                      in_valid;
	logic                      in_ready;
	logic [CODE_W-1:0]         adc_code;
	logic                      out_valid;
	logic                      out_ready;
	logic signed [TEMP_W-1:0]  temperature_c;
	logic                      cal_error;

	typedef struct {
		logic signed [TEMP_W-1:0] temp;
		logic                     err;
	} temp_word_t;

	temp_word_t temp_queue[$];
	logic [CODE_W-1:0] code_low;
	logic [CODE_W-1:0] code_high;
	int errors;
	bit stall_out;

	adc_code_to_temperature_unit uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .adc_code(adc_code),
		.out_valid(out_valid), .out_ready(out_ready),
		.temperature_c(temperature_c), .cal_error(cal_error)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic temp_word_t predict_temp(logic [CODE_W-1:0] code);
		longint a, b, s, sx, sy, sxx, sxy, den, icpt, slope, tenths, deg;
		temp_word_t w;
		a = code_low;
		b = code_high;
		s = code;
		sx = a + b;
		sy = 115;
		sxx = a * a + b * b;
		sxy = a * 30 + b * 85;
		den = 2 * sxx - sx * sx;
		if (den == 0) begin
			w.temp = 0;
			w.err = 1;
			return w;
		end
		icpt = ((sy * sxx - sx * sxy) / den) * 100;
		slope = (100 * (2 * sxy - sx * sy)) / den;
		tenths = (s * slope + icpt) / 10;
		deg = tenths / 10;
		if (tenths > 0 && (tenths % 10) > 4)
			deg += 1;
		if (deg > 32767)
			deg = 32767;
		else if (deg < -32768)
			deg = -32768;
		w.temp = deg[TEMP_W-1:0];
		w.err = 0;
		return w;
	endfunction

	// valid stays up between back to back words; callers drop it before idling
	task automatic send_code(logic [CODE_W-1:0] code, bit gaps);
		int wait_n;
		wait_n = gaps ? $urandom_range(0, 19) : 0;
		if (wait_n > 0) begin
			in_valid <= 0;
			repeat (wait_n) @(negedge clk);
		end
		in_valid <= 1;
		adc_code <= code;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		temp_queue.push_back(predict_temp(code));
		@(negedge clk);
	endtask

	task automatic write_cal(logic [CFG_IDX_W-1:0] idx, logic [CODE_W-1:0] value);
		in_valid <= 0;
		while (temp_queue.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == CFG_CAL_LOW)
			code_low = value;
		else
			code_high = value;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic set_cal(logic [CODE_W-1:0] lo, logic [CODE_W-1:0] hi);
		write_cal(CFG_CAL_LOW, lo);
		write_cal(CFG_CAL_HIGH, hi);
	endtask

	// output checker with random back pressure
	initial begin
		int hold;
		temp_word_t exp_w;
		hold = 0;
		out_ready = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (temp_queue.size() == 0) begin
					$display("%0t unexpected word temp %0d err %0b", $time,
						temperature_c, cal_error);
					errors++;
				end else begin
					exp_w = temp_queue.pop_front();
					if (temperature_c !== exp_w.temp) begin
						$display("%0t temperature_c expected %0d actual %0d", $time,
							exp_w.temp, temperature_c);
						errors++;
					end
					if (cal_error !== exp_w.err) begin
						$display("%0t cal_error expected %0b actual %0b", $time,
							exp_w.err, cal_error);
						errors++;
					end
				end
				if (stall_out)
					hold = $urandom_range(0, 19);
			end
			@(negedge clk);
			if (hold > 0) begin
				out_ready <= 0;
				hold--;
			end else begin
				out_ready <= 1;
			end
		end
	end

	task automatic test_reset_cal();
		send_code(0, 0);
		send_code(12'hFFF, 0);
		send_code(12'h555, 1);
	endtask

	task automatic test_directed();
		set_cal(12'd800, 12'd1000);
		send_code(0, 0);
		send_code(12'hFFF, 0);
		send_code(12'd800, 0);
		send_code(12'd1000, 0);
		send_code(12'd900, 0);
		send_code(12'd801, 0);
		send_code(12'd799, 0);
		set_cal(12'd1000, 12'd1000);
		send_code(12'd123, 0);
		set_cal(12'hFFF, 12'd0);
		send_code(0, 0);
		send_code(12'hFFF, 0);
		set_cal(12'd0, 12'd1);
		send_code(0, 0);
		send_code(12'hFFF, 0);
		set_cal(12'd0, 12'hFFF);
		send_code(12'hAAA, 0);
		send_code(12'h555, 0);
	endtask

	task automatic test_random();
		int n;
		for (int p = 0; p < 11; p++) begin
			case (p % 4)
				0: set_cal(CODE_W'($urandom_range(500, 1500)),
					CODE_W'($urandom_range(500, 1500)));
				1: set_cal(CODE_W'($urandom), CODE_W'($urandom));
				2: set_cal(CODE_W'($urandom_range(0, 3)),
					CODE_W'($urandom_range(4092, 4095)));
				default: begin
					n = $urandom_range(0, 4095);
					set_cal(CODE_W'(n), CODE_W'(n + $urandom_range(0, 2)));
				end
			endcase
			stall_out = (p % 3) != 2;
			for (int i = 0; i < 100; i++)
				send_code(CODE_W'($urandom), (i % 50) < 35);
		end
	endtask

	initial begin
		int drain;
		errors = 0;
		stall_out = 1;
		code_low = 0;
		code_high = 0;
		arst_n = 0;
		cfg_valid = 0;
		cfg_index = CFG_CAL_LOW;
		cfg_data = 0;
		in_valid = 0;
		adc_code = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		test_reset_cal();
		test_directed();
		test_random();
		in_valid <= 0;
		drain = 0;
		while (temp_queue.size() != 0 && drain < 100000) begin
			@(negedge clk);
			drain++;
		end
		repeat (20) @(negedge clk);
		if (errors == 0 && temp_queue.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#5000000;
		$display("status: fail");
		$finish;
	end

endmodule
